// ===== src/tam_pkg.sv =====
package tam_pkg;

    // Field and register widths
    localparam int PIX_W       = 8;
    localparam int CHANNELS    = 3;
    localparam int TILE_IDX_W  = 12;
    localparam int DIM_CFG_W   = 13;
    localparam int TILE_CFG_W  = 8;
    localparam int RECIP_W     = 25;
    localparam int FRAC_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;

    // Output queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_RECIP   = 3'd4;

    // Lane 0 red, lane 1 green, lane 2 blue
    typedef logic [CHANNELS-1:0][PIX_W-1:0] t_rgb;

    // Tile identity carried alongside a pixel
    typedef struct packed {
        logic [TILE_IDX_W-1:0] col;
        logic [TILE_IDX_W-1:0] row;
        logic                  emit;
        logic                  frame_done;
    } t_tag;

    // One finished tile
    typedef struct packed {
        logic [TILE_IDX_W-1:0] col;
        logic [TILE_IDX_W-1:0] row;
        t_rgb                  avg;
        logic                  frame_done;
    } t_result;

endpackage

// ===== src/tam_ram.sv =====
module tam_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tam_scan.sv =====
module tam_scan import tam_pkg::*; #(
    parameter int MAX_TILE_COLS = 512,
    parameter int MAX_DIM = 4096,
    localparam int AW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [DIM_CFG_W-1:0]  i_image_width,
    input  logic [DIM_CFG_W-1:0]  i_image_height,
    input  logic [TILE_CFG_W-1:0] i_tile_width,
    input  logic [TILE_CFG_W-1:0] i_tile_height,
    output logic [AW-1:0]         o_addr,
    output logic                  o_col_ok,
    output logic                  o_first,
    output t_tag                  o_tag
);

    localparam int PW = $clog2(MAX_DIM);
    localparam int DW = PW + 1;
    localparam int CW = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;

    logic [PW-1:0]         r_pixel_x;
    logic [PW-1:0]         r_pixel_y;
    logic [TILE_CFG_W-1:0] r_x_in_tile;
    logic [TILE_CFG_W-1:0] r_y_in_tile;
    logic [PW-1:0]         r_tile_col;
    logic [PW-1:0]         r_tile_row;

    logic [DW-1:0]         w_eff;
    logic [DW-1:0]         h_eff;
    logic [TILE_CFG_W-1:0] tw_eff;
    logic [TILE_CFG_W-1:0] th_eff;
    logic                  line_end;
    logic                  image_end;
    logic                  last_x;
    logic                  last_y;

    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
        logic [CW-1:0] e;
        e = CW'(v);
        if (v == '0) begin
            return DW'(1);
        end else if (e > CW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return DW'(e);
    endfunction

    // Effective limits
    assign w_eff  = clamp_dim(i_image_width);
    assign h_eff  = clamp_dim(i_image_height);
    assign tw_eff = (i_tile_width == '0) ? TILE_CFG_W'(1) : i_tile_width;
    assign th_eff = (i_tile_height == '0) ? TILE_CFG_W'(1) : i_tile_height;

    // Edge detection for the current pixel
    assign line_end  = (DW'(r_pixel_x) + DW'(1)) >= w_eff;
    assign image_end = (DW'(r_pixel_y) + DW'(1)) >= h_eff;
    assign last_x    = (({1'b0, r_x_in_tile} + 9'd1) >= {1'b0, tw_eff}) || line_end;
    assign last_y    = (({1'b0, r_y_in_tile} + 9'd1) >= {1'b0, th_eff}) || image_end;

    // Describe the current pixel
    assign o_addr           = AW'(r_tile_col);
    assign o_col_ok         = 32'(r_tile_col) < 32'(MAX_TILE_COLS);
    assign o_first          = (r_x_in_tile == '0) && (r_y_in_tile == '0);
    assign o_tag.col        = TILE_IDX_W'(r_tile_col);
    assign o_tag.row        = TILE_IDX_W'(r_tile_row);
    assign o_tag.emit       = last_x && last_y;
    assign o_tag.frame_done = line_end && image_end;

    // Advance the raster position on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_x   <= '0;
            r_pixel_y   <= '0;
            r_x_in_tile <= '0;
            r_y_in_tile <= '0;
            r_tile_col  <= '0;
            r_tile_row  <= '0;
        end else if (i_advance) begin
            if (line_end) begin
                r_pixel_x   <= '0;
                r_x_in_tile <= '0;
                r_tile_col  <= '0;
                if (image_end) begin
                    r_pixel_y   <= '0;
                    r_y_in_tile <= '0;
                    r_tile_row  <= '0;
                end else begin
                    r_pixel_y <= r_pixel_y + PW'(1);
                    if (last_y) begin
                        r_y_in_tile <= '0;
                        r_tile_row  <= r_tile_row + PW'(1);
                    end else begin
                        r_y_in_tile <= r_y_in_tile + TILE_CFG_W'(1);
                    end
                end
            end else begin
                r_pixel_x <= r_pixel_x + PW'(1);
                if (last_x) begin
                    r_x_in_tile <= '0;
                    r_tile_col  <= r_tile_col + PW'(1);
                end else begin
                    r_x_in_tile <= r_x_in_tile + TILE_CFG_W'(1);
                end
            end
        end
    end

endmodule

// ===== src/tam_accum.sv =====
module tam_accum import tam_pkg::*; #(
    parameter int MAX_TILE_COLS = 512,
    parameter int CHANNEL_SUM_BITS = 24,
    localparam int AW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_req,
    input  logic [AW-1:0]                          i_addr,
    input  logic                                   i_first,
    input  logic                                   i_col_ok,
    input  t_rgb                                   i_pix,
    input  t_tag                                   i_tag,
    output logic                                   o_busy,
    output logic                                   o_a_emit,
    output logic                                   o_b_valid,
    output logic [CHANNELS-1:0][CHANNEL_SUM_BITS-1:0] o_b_sum,
    output t_tag                                   o_b_tag
);

    localparam int SB = CHANNEL_SUM_BITS;
    localparam int WW = CHANNELS * SB;

    // Clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // Read stage
    logic          r_a_vld;
    logic [AW-1:0] r_a_addr;
    logic          r_a_first;
    logic          r_a_col_ok;
    t_rgb          r_a_pix;
    t_tag          r_a_tag;

    // Last write, for a read that raced it
    logic          r_f_vld;
    logic [AW-1:0] r_f_addr;
    logic [WW-1:0] r_f_data;

    // Sum stage
    logic                         r_b_vld;
    logic [CHANNELS-1:0][SB-1:0]  r_b_sum;
    t_tag                         r_b_tag;

    logic [WW-1:0]                rd_data;
    logic [WW-1:0]                base;
    logic [CHANNELS-1:0][SB-1:0]  new_sum;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [WW-1:0]                wdata;

    tam_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_TILE_COLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_req),
        .i_raddr (i_addr),
        .o_rdata (rd_data)
    );

    // Pick the freshest copy of the entry, or restart at a tile's first pixel
    always_comb begin
        if (r_a_first) begin
            base = '0;
        end else if (r_f_vld && (r_f_addr == r_a_addr)) begin
            base = r_f_data;
        end else begin
            base = rd_data;
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            new_sum[ch] = base[ch*SB +: SB] + SB'(r_a_pix[ch]);
        end
    end

    // Write back, or zero entries during the clearing pass
    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else begin
            we    = r_a_vld && r_a_col_ok;
            waddr = r_a_addr;
            wdata = new_sum;
        end
    end

    // Sweep the memory once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MAX_TILE_COLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Track the latest write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (we) begin
            r_f_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_f_addr <= waddr;
            r_f_data <= wdata;
        end
    end

    // Read stage control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_a_addr   <= i_addr;
            r_a_first  <= i_first;
            r_a_col_ok <= i_col_ok;
            r_a_pix    <= i_pix;
            r_a_tag    <= i_tag;
        end
    end

    // Pass finished tiles on; columns beyond the memory average to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld && r_a_tag.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_vld && r_a_tag.emit) begin
            r_b_sum <= r_a_col_ok ? new_sum : '0;
            r_b_tag <= r_a_tag;
        end
    end

    assign o_busy    = r_clr_busy;
    assign o_a_emit  = r_a_vld && r_a_tag.emit;
    assign o_b_valid = r_b_vld;
    assign o_b_sum   = r_b_sum;
    assign o_b_tag   = r_b_tag;

    // No pixel may enter while the memory is being cleared
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_req)
        else $error("pixel request during clearing pass");

endmodule

// ===== src/tam_scale.sv =====
module tam_scale import tam_pkg::*; #(
    parameter int CHANNEL_SUM_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic [CHANNELS-1:0][CHANNEL_SUM_BITS-1:0] i_sum,
    input  t_tag                                      i_tag,
    input  logic [RECIP_W-1:0]                        i_recip,
    output logic                                      o_valid,
    output t_result                                   o_result
);

    localparam int PRW = CHANNEL_SUM_BITS + RECIP_W;

    logic                         r_c_vld;
    logic [CHANNELS-1:0][PRW-1:0] r_c_prod;
    t_tag                         r_c_tag;
    t_rgb                         avg;

    // Multiply each lane by the reciprocal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_c_prod[ch] <= PRW'(i_sum[ch]) * PRW'(i_recip);
            end
            r_c_tag <= i_tag;
        end
    end

    // Drop the fraction and saturate at full scale
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (|r_c_prod[ch][PRW-1:FRAC_W+PIX_W]) begin
                avg[ch] = '1;
            end else begin
                avg[ch] = r_c_prod[ch][FRAC_W +: PIX_W];
            end
        end
    end

    assign o_valid             = r_c_vld;
    assign o_result.col        = r_c_tag.col;
    assign o_result.row        = r_c_tag.row;
    assign o_result.avg        = avg;
    assign o_result.frame_done = r_c_tag.frame_done;

endmodule

// ===== src/tam_ofifo.sv =====
module tam_ofifo import tam_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_result                i_data,
    input  logic                   i_pop,
    output logic                   o_valid,
    output t_result                o_data,
    output logic [OFIFO_CNT_W-1:0] o_count
);

    t_result                r_mem [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] r_wr;
    logic [OFIFO_PTR_W-1:0] r_rd;
    logic [OFIFO_CNT_W-1:0] r_cnt;

    // Store results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + OFIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + OFIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + OFIFO_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - OFIFO_CNT_W'(1);
            end
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    // The input side reserves space, so a push never meets a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < OFIFO_CNT_W'(OFIFO_DEPTH)))
        else $error("result queue overflow");

endmodule

// ===== src/tile_average_mosaic_top.sv =====
// Channel   Direction  Handshake                  Payload
// pixel     in         i_valid / o_ready          i_red_in, i_green_in, i_blue_in
// tile      out        o_valid / i_ready          o_tile_col, o_tile_row, o_red_avg,
//                                                 o_green_avg, o_blue_avg, o_frame_done
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel per cycle while o_ready is high; each pixel is one read-modify-write of its
// tile column's sums in a single-port-write, registered-read memory.
// After its last pixel a tile result passes memory read, add, multiply and the output
// queue. The queue holds eight results and input is held off during the clearing pass
// and when the queue plus the results still in the pipeline would fill it.
// After reset a clearing pass zeroes all MAX_TILE_COLS entries of the column memory,
// one entry a cycle; o_ready stays low meanwhile, configuration writes are taken.
module tile_average_mosaic_top import tam_pkg::*; #(
    parameter int MAX_TILE_COLS = 512,
    parameter int MAX_DIM = 4096,
    parameter int CHANNEL_SUM_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [TILE_IDX_W-1:0] o_tile_col,
    output logic [TILE_IDX_W-1:0] o_tile_row,
    output logic [PIX_W-1:0]      o_red_avg,
    output logic [PIX_W-1:0]      o_green_avg,
    output logic [PIX_W-1:0]      o_blue_avg,
    output logic                  o_frame_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
    localparam int SB = CHANNEL_SUM_BITS;

    logic [DIM_CFG_W-1:0]  r_image_width;
    logic [DIM_CFG_W-1:0]  r_image_height;
    logic [TILE_CFG_W-1:0] r_tile_width;
    logic [TILE_CFG_W-1:0] r_tile_height;
    logic [RECIP_W-1:0]    r_area_recip;

    logic                         accept;
    logic [AW-1:0]                scan_addr;
    logic                         scan_col_ok;
    logic                         scan_first;
    t_tag                         scan_tag;
    t_rgb                         pix;
    logic                         acc_busy;
    logic                         a_emit;
    logic                         b_valid;
    logic [CHANNELS-1:0][SB-1:0]  b_sum;
    t_tag                         b_tag;
    logic                         c_valid;
    t_result                      c_result;
    t_result                      q_data;
    logic [OFIFO_CNT_W-1:0]       q_count;
    logic [OFIFO_CNT_W:0]         occupancy;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_CFG_W'(640);
            r_image_height <= DIM_CFG_W'(480);
            r_tile_width   <= TILE_CFG_W'(8);
            r_tile_height  <= TILE_CFG_W'(8);
            r_area_recip   <= RECIP_W'(262144);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_TILE_WIDTH:   r_tile_width   <= i_cfg_data[TILE_CFG_W-1:0];
                CFG_TILE_HEIGHT:  r_tile_height  <= i_cfg_data[TILE_CFG_W-1:0];
                CFG_AREA_RECIP:   r_area_recip   <= i_cfg_data[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Reserve queue space for every result still in flight
    assign occupancy = {1'b0, q_count} + (OFIFO_CNT_W + 1)'(a_emit)
                     + (OFIFO_CNT_W + 1)'(b_valid) + (OFIFO_CNT_W + 1)'(c_valid);
    assign o_ready   = !acc_busy && (occupancy < (OFIFO_CNT_W + 1)'(OFIFO_DEPTH));
    assign accept    = i_valid && o_ready;

    assign pix[0] = i_red_in;
    assign pix[1] = i_green_in;
    assign pix[2] = i_blue_in;

    tam_scan #(
        .MAX_TILE_COLS (MAX_TILE_COLS),
        .MAX_DIM       (MAX_DIM)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (accept),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_tile_width   (r_tile_width),
        .i_tile_height  (r_tile_height),
        .o_addr         (scan_addr),
        .o_col_ok       (scan_col_ok),
        .o_first        (scan_first),
        .o_tag          (scan_tag)
    );

    tam_accum #(
        .MAX_TILE_COLS    (MAX_TILE_COLS),
        .CHANNEL_SUM_BITS (CHANNEL_SUM_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (accept),
        .i_addr    (scan_addr),
        .i_first   (scan_first),
        .i_col_ok  (scan_col_ok),
        .i_pix     (pix),
        .i_tag     (scan_tag),
        .o_busy    (acc_busy),
        .o_a_emit  (a_emit),
        .o_b_valid (b_valid),
        .o_b_sum   (b_sum),
        .o_b_tag   (b_tag)
    );

    tam_scale #(
        .CHANNEL_SUM_BITS (CHANNEL_SUM_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (b_valid),
        .i_sum    (b_sum),
        .i_tag    (b_tag),
        .i_recip  (r_area_recip),
        .o_valid  (c_valid),
        .o_result (c_result)
    );

    tam_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_valid),
        .i_data  (c_result),
        .i_pop   (o_valid && i_ready),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_tile_col   = q_data.col;
    assign o_tile_row   = q_data.row;
    assign o_red_avg    = q_data.avg[0];
    assign o_green_avg  = q_data.avg[1];
    assign o_blue_avg   = q_data.avg[2];
    assign o_frame_done = q_data.frame_done;

    // Results queued or in flight never exceed the queue depth
    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (OFIFO_CNT_W + 1)'(OFIFO_DEPTH))
        else $error("result occupancy exceeds queue depth");

endmodule
